### src/spt_pkg.sv
// Package with the constants, operation codes and status codes of the slotted page store.
package spt_pkg;

    localparam int PAGE_BYTES   = 4096;
    localparam int HEADER_BYTES = 8;
    localparam int SLOT_BYTES   = 4;
    localparam int MAX_SLOTS    = 1024;

    localparam int ADDR_W     = $clog2(PAGE_BYTES);
    localparam int LEN_W      = ADDR_W + 1;
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int PAGE_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 3;
    localparam int SLOT_MEM_W = ADDR_W + LEN_W;
    localparam int FS_W       = LEN_W + CNT_W + 8;

    localparam logic [ADDR_W-1:0] FREE_TOP = ADDR_W'(PAGE_BYTES - 1);

    typedef enum logic [OP_W-1:0] {
        OP_INIT      = 3'd0,
        OP_INS_BEGIN = 3'd1,
        OP_INS_BYTE  = 3'd2,
        OP_READ_BYTE = 3'd3,
        OP_DELETE    = 3'd4,
        OP_COMPACT   = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NO_SPACE = 3'd1,
        ST_BAD_SLOT = 3'd2,
        ST_BAD_IDX  = 3'd3,
        ST_NO_PEND  = 3'd4
    } status_t;

endpackage

### src/spt_if.sv
// Request and response channel interfaces of the slotted page store.
interface spt_req_if;
    logic                       valid;
    logic                       ready;
    logic [spt_pkg::OP_W-1:0]   operation;
    logic [spt_pkg::PAGE_W-1:0] page_number;
    logic [spt_pkg::SLOT_W-1:0] slot_number;
    logic [spt_pkg::ADDR_W-1:0] byte_index;
    logic [spt_pkg::LEN_W-1:0]  tuple_length;
    logic [spt_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, operation, page_number, slot_number, byte_index,
                    tuple_length, data_byte, input ready);
    modport sink (input valid, operation, page_number, slot_number, byte_index,
                  tuple_length, data_byte, output ready);
endinterface

interface spt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [spt_pkg::STATUS_W-1:0] status;
    logic [spt_pkg::BYTE_W-1:0]   byte_out;
    logic [spt_pkg::LEN_W-1:0]    length_out;
    logic [spt_pkg::SLOT_W-1:0]   slot_assigned;
    logic [spt_pkg::LEN_W-1:0]    free_bytes;
    logic [spt_pkg::CNT_W-1:0]    slot_total;
    logic [spt_pkg::PAGE_W-1:0]   page_number_out;

    modport source (output valid, status, byte_out, length_out, slot_assigned, free_bytes,
                    slot_total, page_number_out, input ready);
    modport sink (input valid, status, byte_out, length_out, slot_assigned, free_bytes,
                  slot_total, page_number_out, output ready);
endinterface

### src/spt_ram.sv
// Generic single write port, single read port RAM with registered read data.
module spt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/slotted_page_tuple_store.sv
// Top level of the slotted page store: operation sequencer around the page and slot RAMs.
//
// Usage: every request item on req carries one operation (init, insert begin,
// insert byte, read byte, delete, compact); each gives exactly one response
// item on rsp with status, read data, and the page counters after the operation.
// Requests are taken one at a time: req.ready is high only while the sequencer
// is idle. Init, insert begin, insert byte and a rejected request go from the
// execute state straight to the response; delete passes through a slot write
// state, and read byte through a slot read state and, when the index check
// passes, a byte read state, as the slot RAM and page RAM have registered read
// data. Compact reads the slot RAM once per slot and reads then writes the page
// RAM once per moved byte.
// The response sits in an output register; a new request is accepted while it
// waits, and the next response holds in the sequencer until rsp.ready frees it.
// Reset empties the page (no slots, free offset at page top, page number zero)
// and clears any pending insert; RAM contents stay undefined until written.
module slotted_page_tuple_store (
    input  logic           clk,
    input  logic           rst_n,
    spt_req_if.sink        req,
    spt_rsp_if.source      rsp
);
    import spt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RD_SLOT,
        S_RD_BYTE,
        S_DEL,
        S_C_RD,
        S_C_CHK,
        S_C_BRD,
        S_C_BWR,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    logic [OP_W-1:0]   op_reg, op_next;
    logic [PAGE_W-1:0] page_in_reg, page_in_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0]  tlen_reg, tlen_next;
    logic [BYTE_W-1:0] data_reg, data_next;

    logic [CNT_W-1:0]  slots_used_reg, slots_used_next;
    logic [ADDR_W-1:0] free_offset_reg, free_offset_next;
    logic [PAGE_W-1:0] stored_page_reg, stored_page_next;
    logic [ADDR_W-1:0] ins_ptr_reg, ins_ptr_next;
    logic [LEN_W-1:0]  ins_rem_reg, ins_rem_next;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [BYTE_W-1:0]   res_byte_reg, res_byte_next;
    logic [LEN_W-1:0]    res_len_reg, res_len_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;

    logic [CNT_W-1:0]  ci_reg, ci_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [LEN_W-1:0]  k_reg, k_next;
    logic [ADDR_W-1:0] src_reg, src_next;
    logic [ADDR_W-1:0] dst_reg, dst_next;
    logic [LEN_W-1:0]  clen_reg, clen_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic [LEN_W-1:0]    out_len_reg, out_len_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [LEN_W-1:0]    out_free_reg, out_free_next;
    logic [CNT_W-1:0]    out_total_reg, out_total_next;
    logic [PAGE_W-1:0]   out_page_reg, out_page_next;

    logic                  page_we;
    logic [ADDR_W-1:0]     page_waddr;
    logic [BYTE_W-1:0]     page_wdata;
    logic [ADDR_W-1:0]     page_raddr;
    logic [BYTE_W-1:0]     page_rdata;
    logic                  slot_we;
    logic [SLOT_W-1:0]     slot_waddr;
    logic [SLOT_MEM_W-1:0] slot_wdata;
    logic [SLOT_W-1:0]     slot_raddr;
    logic [SLOT_MEM_W-1:0] slot_rdata;

    logic signed [FS_W-1:0] avail;
    logic [FS_W-1:0]        free_space;
    logic [LEN_W-1:0]       rd_len;
    logic [ADDR_W-1:0]      rd_off;
    logic                   slot_bad;
    logic                   no_space;

    spt_ram #(.WIDTH(BYTE_W), .DEPTH(PAGE_BYTES)) u_page_ram (
        .clk   (clk),
        .we    (page_we),
        .waddr (page_waddr),
        .wdata (page_wdata),
        .raddr (page_raddr),
        .rdata (page_rdata)
    );

    spt_ram #(.WIDTH(SLOT_MEM_W), .DEPTH(MAX_SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    assign avail = $signed(FS_W'(free_offset_reg)) + $signed(FS_W'(1))
                 - $signed(FS_W'(HEADER_BYTES))
                 - $signed(FS_W'(slots_used_reg) * FS_W'(SLOT_BYTES));
    assign free_space = avail[FS_W-1] ? '0 : avail;
    assign rd_len     = slot_rdata[LEN_W-1:0];
    assign rd_off     = slot_rdata[SLOT_MEM_W-1:LEN_W];
    assign slot_bad   = CNT_W'(slot_reg) >= slots_used_reg;
    assign no_space   = (slots_used_reg >= CNT_W'(MAX_SLOTS))
                     || ((FS_W'(tlen_reg) + FS_W'(SLOT_BYTES)) > free_space);

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.byte_out        = out_byte_reg;
    assign rsp.length_out      = out_len_reg;
    assign rsp.slot_assigned   = out_slot_reg;
    assign rsp.free_bytes      = out_free_reg;
    assign rsp.slot_total      = out_total_reg;
    assign rsp.page_number_out = out_page_reg;

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        page_in_next     = page_in_reg;
        slot_next        = slot_reg;
        idx_next         = idx_reg;
        tlen_next        = tlen_reg;
        data_next        = data_reg;
        slots_used_next  = slots_used_reg;
        free_offset_next = free_offset_reg;
        stored_page_next = stored_page_reg;
        ins_ptr_next     = ins_ptr_reg;
        ins_rem_next     = ins_rem_reg;
        res_status_next  = res_status_reg;
        res_byte_next    = res_byte_reg;
        res_len_next     = res_len_reg;
        res_slot_next    = res_slot_reg;
        ci_next          = ci_reg;
        wp_next          = wp_reg;
        k_next           = k_reg;
        src_next         = src_reg;
        dst_next         = dst_reg;
        clen_next        = clen_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_byte_next    = out_byte_reg;
        out_len_next     = out_len_reg;
        out_slot_next    = out_slot_reg;
        out_free_next    = out_free_reg;
        out_total_next   = out_total_reg;
        out_page_next    = out_page_reg;
        page_we          = 1'b0;
        page_waddr       = ins_ptr_reg;
        page_wdata       = data_reg;
        page_raddr       = '0;
        slot_we          = 1'b0;
        slot_waddr       = slots_used_reg[SLOT_W-1:0];
        slot_wdata       = '0;
        slot_raddr       = slot_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next      = req.operation;
                    page_in_next = req.page_number;
                    slot_next    = req.slot_number;
                    idx_next     = req.byte_index;
                    tlen_next    = req.tuple_length;
                    data_next    = req.data_byte;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_status_next = ST_OK;
                res_byte_next   = '0;
                res_len_next    = '0;
                res_slot_next   = '0;
                state_next      = S_FIN;
                case (op_reg)
                    OP_INIT:
                    begin
                        stored_page_next = page_in_reg;
                        slots_used_next  = '0;
                        free_offset_next = FREE_TOP;
                        ins_rem_next     = '0;
                    end
                    OP_INS_BEGIN:
                    begin
                        if (no_space)
                        begin
                            res_status_next = ST_NO_SPACE;
                        end
                        else
                        begin
                            slot_we          = 1'b1;
                            slot_wdata       = {free_offset_reg + ADDR_W'(1)
                                                - tlen_reg[ADDR_W-1:0], tlen_reg};
                            res_slot_next    = slots_used_reg[SLOT_W-1:0];
                            slots_used_next  = slots_used_reg + CNT_W'(1);
                            free_offset_next = free_offset_reg - tlen_reg[ADDR_W-1:0];
                            ins_ptr_next     = free_offset_reg + ADDR_W'(1)
                                             - tlen_reg[ADDR_W-1:0];
                            ins_rem_next     = tlen_reg;
                        end
                    end
                    OP_INS_BYTE:
                    begin
                        if (ins_rem_reg == '0)
                        begin
                            res_status_next = ST_NO_PEND;
                        end
                        else
                        begin
                            page_we      = 1'b1;
                            ins_ptr_next = ins_ptr_reg + ADDR_W'(1);
                            ins_rem_next = ins_rem_reg - LEN_W'(1);
                        end
                    end
                    OP_READ_BYTE:
                    begin
                        if (slot_bad)
                        begin
                            res_status_next = ST_BAD_SLOT;
                        end
                        else
                        begin
                            state_next = S_RD_SLOT;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (slot_bad)
                        begin
                            res_status_next = ST_BAD_SLOT;
                        end
                        else
                        begin
                            state_next = S_DEL;
                        end
                    end
                    OP_COMPACT:
                    begin
                        ins_rem_next = '0;
                        ci_next      = '0;
                        wp_next      = FREE_TOP;
                        state_next   = S_C_RD;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_RD_SLOT:
            begin
                res_len_next = rd_len;
                page_raddr   = rd_off + idx_reg;
                if (LEN_W'(idx_reg) >= rd_len)
                begin
                    res_status_next = ST_BAD_IDX;
                    state_next      = S_FIN;
                end
                else
                begin
                    state_next = S_RD_BYTE;
                end
            end
            S_RD_BYTE:
            begin
                res_byte_next = page_rdata;
                state_next    = S_FIN;
            end
            S_DEL:
            begin
                slot_we    = 1'b1;
                slot_waddr = slot_reg;
                slot_wdata = {rd_off, LEN_W'(0)};
                state_next = S_FIN;
            end
            S_C_RD:
            begin
                slot_raddr = ci_reg[SLOT_W-1:0];
                if (ci_reg >= slots_used_reg)
                begin
                    free_offset_next = wp_reg;
                    state_next       = S_FIN;
                end
                else
                begin
                    state_next = S_C_CHK;
                end
            end
            S_C_CHK:
            begin
                if (rd_len == '0)
                begin
                    ci_next    = ci_reg + CNT_W'(1);
                    state_next = S_C_RD;
                end
                else
                begin
                    clen_next  = rd_len;
                    k_next     = rd_len - LEN_W'(1);
                    src_next   = rd_off;
                    dst_next   = wp_reg - rd_len[ADDR_W-1:0] + ADDR_W'(1);
                    state_next = S_C_BRD;
                end
            end
            S_C_BRD:
            begin
                page_raddr = src_reg + k_reg[ADDR_W-1:0];
                state_next = S_C_BWR;
            end
            S_C_BWR:
            begin
                page_we    = 1'b1;
                page_waddr = dst_reg + k_reg[ADDR_W-1:0];
                page_wdata = page_rdata;
                if (k_reg == '0)
                begin
                    slot_we    = 1'b1;
                    slot_waddr = ci_reg[SLOT_W-1:0];
                    slot_wdata = {dst_reg, clen_reg};
                    wp_next    = dst_reg - ADDR_W'(1);
                    ci_next    = ci_reg + CNT_W'(1);
                    state_next = S_C_RD;
                end
                else
                begin
                    k_next     = k_reg - LEN_W'(1);
                    state_next = S_C_BRD;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_byte_next   = res_byte_reg;
                    out_len_next    = res_len_reg;
                    out_slot_next   = res_slot_reg;
                    out_free_next   = free_space[LEN_W-1:0];
                    out_total_next  = slots_used_reg;
                    out_page_next   = stored_page_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            slots_used_reg  <= '0;
            free_offset_reg <= FREE_TOP;
            stored_page_reg <= '0;
            ins_ptr_reg     <= '0;
            ins_rem_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            slots_used_reg  <= slots_used_next;
            free_offset_reg <= free_offset_next;
            stored_page_reg <= stored_page_next;
            ins_ptr_reg     <= ins_ptr_next;
            ins_rem_reg     <= ins_rem_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        page_in_reg    <= page_in_next;
        slot_reg       <= slot_next;
        idx_reg        <= idx_next;
        tlen_reg       <= tlen_next;
        data_reg       <= data_next;
        res_status_reg <= res_status_next;
        res_byte_reg   <= res_byte_next;
        res_len_reg    <= res_len_next;
        res_slot_reg   <= res_slot_next;
        ci_reg         <= ci_next;
        wp_reg         <= wp_next;
        k_reg          <= k_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        clen_reg       <= clen_next;
        out_status_reg <= out_status_next;
        out_byte_reg   <= out_byte_next;
        out_len_reg    <= out_len_next;
        out_slot_reg   <= out_slot_next;
        out_free_reg   <= out_free_next;
        out_total_reg  <= out_total_next;
        out_page_reg   <= out_page_next;
    end

endmodule

### verif/tb_top.sv
// Testbench for the slotted page tuple store: directed table plus random operations against a predictor.
module tb_top;
    import spt_pkg::*;

    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;
    localparam int RANDOM_ITEMS = 1050;
    localparam int QUIET_ITEMS  = 150;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] idx;
        logic [LEN_W-1:0]  tlen;
        logic [BYTE_W-1:0] data;
    } page_op_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   byte_out;
        logic [LEN_W-1:0]    length_out;
        logic [SLOT_W-1:0]   slot_assigned;
        logic [LEN_W-1:0]    free_bytes;
        logic [CNT_W-1:0]    slot_total;
        logic [PAGE_W-1:0]   page_out;
    } page_rsp_t;

    typedef struct {
        page_op_t  op;
        bit        typed;
        page_rsp_t rsp;
    } table_row_t;

    logic clk;
    logic rst_n;

    spt_req_if req ();
    spt_rsp_if rsp ();

    slotted_page_tuple_store i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // page image kept by the predictor
    logic [BYTE_W-1:0] page_mem [PAGE_BYTES];
    bit                byte_written [PAGE_BYTES];
    int                slot_off [MAX_SLOTS];
    int                slot_len [MAX_SLOTS];
    int                used_slots;
    int                free_off;
    logic [PAGE_W-1:0] cur_page;
    int                ins_ptr;
    int                ins_left;

    page_rsp_t  pending_rsp_q [$];
    table_row_t dir_rows [$];
    int         errors;
    int         cycles;
    int         rsp_count;
    bit         quiet;

    function automatic int wrap_addr(input int a);
        return ((a % PAGE_BYTES) + PAGE_BYTES) % PAGE_BYTES;
    endfunction

    function automatic int free_space();
        int a;
        a = free_off + 1 - HEADER_BYTES - used_slots * SLOT_BYTES;
        return (a < 0) ? 0 : a;
    endfunction

    function automatic void compact_tuples();
        int wp;
        int dst;
        int d;
        int s;
        wp = PAGE_BYTES - 1;
        for (int i = 0; i < used_slots; i++)
        begin
            if (slot_len[i] == 0)
                continue;
            dst = wp - slot_len[i] + 1;
            for (int k = slot_len[i] - 1; k >= 0; k--)
            begin
                d = wrap_addr(dst + k);
                s = wrap_addr(slot_off[i] + k);
                page_mem[d] = page_mem[s];
                byte_written[d] = byte_written[s];
            end
            slot_off[i] = wrap_addr(dst);
            wp = dst - 1;
        end
        free_off = wrap_addr(wp);
    endfunction

    function automatic page_rsp_t apply_page_op(input page_op_t o);
        page_rsp_t r;
        int start;
        int a;
        r = '{default: '0};
        r.status = ST_OK;
        case (o.op)
            OP_INIT:
            begin
                cur_page = o.page;
                used_slots = 0;
                free_off = PAGE_BYTES - 1;
                ins_left = 0;
            end
            OP_INS_BEGIN:
            begin
                if (used_slots >= MAX_SLOTS || int'(o.tlen) + SLOT_BYTES > free_space())
                    r.status = ST_NO_SPACE;
                else
                begin
                    start = free_off + 1 - int'(o.tlen);
                    slot_off[used_slots] = start;
                    slot_len[used_slots] = int'(o.tlen);
                    r.slot_assigned = SLOT_W'(used_slots);
                    used_slots++;
                    free_off = start - 1;
                    ins_ptr = start;
                    ins_left = int'(o.tlen);
                end
            end
            OP_INS_BYTE:
            begin
                if (ins_left == 0)
                    r.status = ST_NO_PEND;
                else
                begin
                    a = wrap_addr(ins_ptr);
                    page_mem[a] = o.data;
                    byte_written[a] = 1'b1;
                    ins_ptr++;
                    ins_left--;
                end
            end
            OP_READ_BYTE:
            begin
                if (int'(o.slot) >= used_slots)
                    r.status = ST_BAD_SLOT;
                else
                begin
                    r.length_out = LEN_W'(slot_len[o.slot]);
                    if (int'(o.idx) >= slot_len[o.slot])
                        r.status = ST_BAD_IDX;
                    else
                        r.byte_out = page_mem[wrap_addr(slot_off[o.slot] + int'(o.idx))];
                end
            end
            OP_DELETE:
            begin
                if (int'(o.slot) >= used_slots)
                    r.status = ST_BAD_SLOT;
                else
                    slot_len[o.slot] = 0;
            end
            OP_COMPACT:
            begin
                ins_left = 0;
                compact_tuples();
            end
            default: ;
        endcase
        r.free_bytes = LEN_W'(free_space());
        r.slot_total = CNT_W'(used_slots);
        r.page_out = cur_page;
        return r;
    endfunction

    // first live slot with a byte never written, or -1
    function automatic int unfinished_slot();
        for (int i = 0; i < used_slots; i++)
            for (int k = 0; k < slot_len[i]; k++)
                if (!byte_written[wrap_addr(slot_off[i] + k)])
                    return i;
        return -1;
    endfunction

    function automatic page_op_t random_page_op();
        page_op_t o;
        int pick;
        int u;
        o.op = OP_READ_BYTE;
        o.page = $urandom;
        o.slot = SLOT_W'($urandom);
        o.idx = ADDR_W'($urandom);
        o.tlen = LEN_W'($urandom_range(0, 24));
        o.data = BYTE_W'($urandom);
        pick = $urandom_range(0, 99);
        if (ins_left > 0 && pick < 80)
            o.op = OP_INS_BYTE;
        else if (pick < 30)
        begin
            o.op = OP_INS_BEGIN;
            if ($urandom_range(0, 39) == 0)
                o.tlen = LEN_W'($urandom_range(0, PAGE_BYTES));
        end
        else if (pick < 70)
        begin
            o.op = OP_READ_BYTE;
            if (used_slots > 0 && $urandom_range(0, 6) != 0)
            begin
                o.slot = SLOT_W'($urandom_range(0, used_slots - 1));
                if (slot_len[o.slot] > 0 && $urandom_range(0, 4) != 0)
                    o.idx = ADDR_W'($urandom_range(0, slot_len[o.slot] - 1));
            end
        end
        else if (pick < 80)
        begin
            o.op = OP_DELETE;
            if (used_slots > 0 && $urandom_range(0, 5) != 0)
                o.slot = SLOT_W'($urandom_range(0, used_slots - 1));
        end
        else if (pick < 88)
            o.op = OP_COMPACT;
        else if (pick < 92)
            o.op = OP_INIT;
        else if (pick < 97)
            o.op = OP_INS_BYTE;
        else
            o.op = $urandom_range(0, 1) ? OP_RSVD_6 : OP_RSVD_7;
        // keep clear of page bytes that were never written
        if (o.op == OP_READ_BYTE && int'(o.slot) < used_slots && int'(o.idx) < slot_len[o.slot])
            if (!byte_written[wrap_addr(slot_off[o.slot] + int'(o.idx))])
                o.idx = ADDR_W'(slot_len[o.slot]);
        if (o.op == OP_COMPACT)
        begin
            u = unfinished_slot();
            if (u >= 0)
            begin
                o.op = OP_DELETE;
                o.slot = SLOT_W'(u);
            end
        end
        return o;
    endfunction

    function automatic table_row_t mk_row(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] pg,
                                          input int sl, input int ix, input int tl, input int db,
                                          input bit typed, input status_t st, input int bo,
                                          input int lo, input int asg, input int fb,
                                          input int tot, input logic [PAGE_W-1:0] pgo);
        table_row_t t;
        t.op = '{op, pg, SLOT_W'(sl), ADDR_W'(ix), LEN_W'(tl), BYTE_W'(db)};
        t.typed = typed;
        t.rsp = '{st, BYTE_W'(bo), LEN_W'(lo), SLOT_W'(asg), LEN_W'(fb), CNT_W'(tot), pgo};
        return t;
    endfunction

    task automatic send_page_op(input page_op_t o, input page_rsp_t e);
        req.valid <= 1'b1;
        req.operation <= o.op;
        req.page_number <= o.page;
        req.slot_number <= o.slot;
        req.byte_index <= o.idx;
        req.tuple_length <= o.tlen;
        req.data_byte <= o.data;
        do
            @(posedge clk);
        while (!req.ready);
        pending_rsp_q.push_back(e);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // response side: random stalls, one long hold-off
    int  stall_left;
    bit  held;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!held && rsp_count >= HOLD_AT)
            begin
                held = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        page_rsp_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            rsp_count <= rsp_count + 1;
            if (pending_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected item, exp none got status %0d", $time, rsp.status);
                errors++;
            end
            else
            begin
                e = pending_rsp_q.pop_front();
                if (rsp.status !== e.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, rsp.status);
                    errors++;
                end
                if (rsp.byte_out !== e.byte_out)
                begin
                    $display("%0t: byte_out exp %0h got %0h", $time, e.byte_out, rsp.byte_out);
                    errors++;
                end
                if (rsp.length_out !== e.length_out)
                begin
                    $display("%0t: length_out exp %0d got %0d", $time, e.length_out,
                             rsp.length_out);
                    errors++;
                end
                if (rsp.slot_assigned !== e.slot_assigned)
                begin
                    $display("%0t: slot_assigned exp %0d got %0d", $time, e.slot_assigned,
                             rsp.slot_assigned);
                    errors++;
                end
                if (rsp.free_bytes !== e.free_bytes)
                begin
                    $display("%0t: free_bytes exp %0d got %0d", $time, e.free_bytes,
                             rsp.free_bytes);
                    errors++;
                end
                if (rsp.slot_total !== e.slot_total)
                begin
                    $display("%0t: slot_total exp %0d got %0d", $time, e.slot_total,
                             rsp.slot_total);
                    errors++;
                end
                if (rsp.page_number_out !== e.page_out)
                begin
                    $display("%0t: page_number_out exp %0h got %0h", $time, e.page_out,
                             rsp.page_number_out);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        page_rsp_t e;
        page_op_t  o;
        int        waited;
        errors = 0;
        cycles = 0;
        rsp_count = 0;
        quiet = 1'b0;
        stall_left = 0;
        held = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.operation = OP_INIT;
        req.page_number = '0;
        req.slot_number = '0;
        req.byte_index = '0;
        req.tuple_length = '0;
        req.data_byte = '0;
        rsp.ready = 1'b0;
        for (int i = 0; i < PAGE_BYTES; i++)
        begin
            page_mem[i] = '0;
            byte_written[i] = 1'b0;
        end
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            slot_off[i] = 0;
            slot_len[i] = 0;
        end
        used_slots = 0;
        free_off = PAGE_BYTES - 1;
        cur_page = '0;
        ins_ptr = 0;
        ins_left = 0;

        dir_rows.push_back(mk_row(OP_INIT, 32'hFFFF_FFFF, 0, 0, 0, 0,
                                  1, ST_OK, 0, 0, 0, 4088, 0, 32'hFFFF_FFFF));
        dir_rows.push_back(mk_row(OP_INS_BYTE, 0, 0, 0, 0, 8'h11,
                                  1, ST_NO_PEND, 0, 0, 0, 4088, 0, 32'hFFFF_FFFF));
        dir_rows.push_back(mk_row(OP_READ_BYTE, 0, 0, 0, 0, 0,
                                  1, ST_BAD_SLOT, 0, 0, 0, 4088, 0, 32'hFFFF_FFFF));
        dir_rows.push_back(mk_row(OP_DELETE, 0, 1023, 0, 0, 0,
                                  1, ST_BAD_SLOT, 0, 0, 0, 4088, 0, 32'hFFFF_FFFF));
        dir_rows.push_back(mk_row(OP_INS_BEGIN, 0, 0, 0, 4096, 0,
                                  1, ST_NO_SPACE, 0, 0, 0, 4088, 0, 32'hFFFF_FFFF));
        dir_rows.push_back(mk_row(OP_INS_BEGIN, 0, 0, 0, 0, 0,
                                  1, ST_OK, 0, 0, 0, 4084, 1, 32'hFFFF_FFFF));
        dir_rows.push_back(mk_row(OP_INS_BEGIN, 0, 0, 0, 3, 0,
                                  1, ST_OK, 0, 0, 1, 4077, 2, 32'hFFFF_FFFF));
        dir_rows.push_back(mk_row(OP_INS_BYTE, 0, 0, 0, 0, 8'h00, 0, ST_OK, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_INS_BYTE, 0, 0, 0, 0, 8'hFF, 0, ST_OK, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_INS_BYTE, 0, 0, 0, 0, 8'hA5, 0, ST_OK, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_READ_BYTE, 0, 1, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_READ_BYTE, 0, 1, 2, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_READ_BYTE, 0, 1, 4095, 0, 0,
                                  1, ST_BAD_IDX, 0, 3, 0, 4077, 2, 32'hFFFF_FFFF));
        dir_rows.push_back(mk_row(OP_READ_BYTE, 0, 0, 0, 0, 0,
                                  1, ST_BAD_IDX, 0, 0, 0, 4077, 2, 32'hFFFF_FFFF));
        dir_rows.push_back(mk_row(OP_INS_BEGIN, 0, 0, 0, 2, 0, 0, ST_OK, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_INS_BYTE, 0, 0, 0, 0, 8'h5A, 0, ST_OK, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_INS_BEGIN, 0, 0, 0, 2, 0, 0, ST_OK, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_INS_BYTE, 0, 0, 0, 0, 8'h3C, 0, ST_OK, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_INS_BYTE, 0, 0, 0, 0, 8'hC3, 0, ST_OK, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_DELETE, 0, 2, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_COMPACT, 0, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_READ_BYTE, 0, 3, 1, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_RSVD_6, 0, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_RSVD_7, 0, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_INIT, 0, 0, 0, 0, 0,
                                  1, ST_OK, 0, 0, 0, 4088, 0, 0));
        dir_rows.push_back(mk_row(OP_INS_BEGIN, 0, 0, 0, 4084, 0,
                                  1, ST_OK, 0, 0, 0, 0, 1, 0));
        dir_rows.push_back(mk_row(OP_INS_BEGIN, 0, 0, 0, 0, 0,
                                  1, ST_NO_SPACE, 0, 0, 0, 0, 1, 0));
        dir_rows.push_back(mk_row(OP_INIT, 32'h1234_5678, 0, 0, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0, 0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            e = apply_page_op(dir_rows[i].op);
            if (dir_rows[i].typed)
                e = dir_rows[i].rsp;
            send_page_op(dir_rows[i].op, e);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            o = random_page_op();
            e = apply_page_op(o);
            send_page_op(o, e);
        end
        req.valid <= 1'b0;

        waited = 0;
        while (pending_rsp_q.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_rsp_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
